// File: sv/huffman_table_encoder_bit_packer_macros.svh
// Assertion macros for the table encoder and bit packer.
// Included by the RTL files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef HUFFMAN_TABLE_ENCODER_BIT_PACKER_MACROS_SVH
`define HUFFMAN_TABLE_ENCODER_BIT_PACKER_MACROS_SVH

`ifndef ASSERT_OFF
`define HTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define HTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HTE_ASSERT_IMP(lbl, ante, cons, msg)
`define HTE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/hte_pkg.sv
// Shared types and constants of the table encoder and bit packer.
// No dependencies; imported by every module of the block.
package hte_pkg;

	localparam int SYMBOL_COUNT = 256;
	localparam int MAX_CODE_LEN = 32;
	localparam int SYM_W        = 8;
	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int BYTE_W       = 8;
	localparam int ACC_W        = BYTE_W - 1;
	localparam int CNT_W        = 3;
	localparam int WORK_W       = CODE_W + BYTE_W;
	localparam int REM_W        = 6;
	localparam int SHAMT_W      = 6;
	localparam int TBL_AW       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_MERGE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               left;
		logic [SHAMT_W-1:0] amt;
	} shift_req_t;

endpackage

// File: sv/hte_table.sv
// Code table: one entry of code and length per symbol, with a valid bit per entry.
// Depends on hte_pkg; entries not yet loaded read back with zero length.
module hte_table import hte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [TBL_AW-1:0] wr_addr,
	input  logic [CODE_W-1:0] wr_code,
	input  logic [LEN_W-1:0]  wr_len,
	input  logic              rd_en,
	input  logic [TBL_AW-1:0] rd_addr,
	output logic [CODE_W-1:0] rd_code,
	output logic [LEN_W-1:0]  rd_len
);

	logic [CODE_W+LEN_W-1:0] mem_q [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] vld_q;
	logic [CODE_W+LEN_W-1:0] rd_word_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_code, wr_len};
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_code = rd_word_q[CODE_W+LEN_W-1:LEN_W];
	assign rd_len  = rd_vld_q ? rd_word_q[LEN_W-1:0] : '0;

endmodule

// File: sv/hte_shift.sv
// Shared barrel shifter of the packer working register, left or right.
// Depends on hte_pkg for the register width and the request struct.
module hte_shift import hte_pkg::*; (
	input  logic [WORK_W-1:0] data_in,
	input  shift_req_t        req,
	output logic [WORK_W-1:0] data_out
);

	always_comb begin
		if (req.left) begin
			data_out = data_in << req.amt;
		end else begin
			data_out = data_in >> req.amt;
		end
	end

endmodule

// File: sv/huffman_table_encoder_bit_packer.sv
// Table-driven prefix-code encoder with an MSB-first byte packer. A load writes one table entry.
// An encode reads the table, aligns the code, merges it with the pending bits, then emits each
// completed byte, up to four, and closes; a flush with pending bits emits one byte and closes.
// The alignment, merge and byte-shift steps go through one shared 40-bit shifter, and the output
// register moves one byte per cycle while the receiver takes them. A byte that the receiver has
// not yet taken holds the sequencer in its emit step. The next item is taken while the last byte
// still waits in the output register. Reset clears all table entries to zero length at once.
module huffman_table_encoder_bit_packer import hte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [1:0]        operation,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [CODE_W-1:0] code_bits,
	input  logic [LEN_W-1:0]  code_length,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last_byte
);

`include "huffman_table_encoder_bit_packer_macros.svh"

	state_t            state_q, state_d;
	logic [WORK_W-1:0] w_q, w_d;
	logic [REM_W-1:0]  r_q, r_d;
	logic [ACC_W-1:0]  acc_q, acc_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              ov_q, ov_d;
	logic [BYTE_W-1:0] ob_q, ob_d;
	logic              lb_q, lb_d;

	op_t               op;
	logic              sym_ok;
	logic              tbl_wr, tbl_rd;
	logic [LEN_W-1:0]  len_clamped;
	logic [CODE_W-1:0] rd_code;
	logic [LEN_W-1:0]  rd_len;
	shift_req_t        sh_req;
	logic [WORK_W-1:0] sh_in, sh_out;

	assign op          = op_t'(operation);
	assign sym_ok      = ({1'b0, symbol} < (SYM_W+1)'(SYMBOL_COUNT));
	assign len_clamped = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;

	hte_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr),
		.wr_addr (symbol[TBL_AW-1:0]),
		.wr_code (code_bits),
		.wr_len  (len_clamped),
		.rd_en   (tbl_rd),
		.rd_addr (symbol[TBL_AW-1:0]),
		.rd_code (rd_code),
		.rd_len  (rd_len)
	);

	hte_shift u_shift (
		.data_in  (sh_in),
		.req      (sh_req),
		.data_out (sh_out)
	);

	always_comb begin
		state_d    = state_q;
		w_d        = w_q;
		r_d        = r_q;
		acc_d      = acc_q;
		cnt_d      = cnt_q;
		ov_d       = ov_q && !result_ready;
		ob_d       = ob_q;
		lb_d       = lb_q;
		tbl_wr     = 1'b0;
		tbl_rd     = 1'b0;
		sh_in      = w_q;
		sh_req     = '{left: 1'b1, amt: SHAMT_W'(BYTE_W)};
		item_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (op)
						OP_LOAD: begin
							tbl_wr = sym_ok;
						end
						OP_ENCODE: begin
							if (sym_ok) begin
								tbl_rd  = 1'b1;
								state_d = ST_ALIGN;
							end
						end
						OP_FLUSH: begin
							if (cnt_q != '0) begin
								w_d     = {acc_q, {(WORK_W-ACC_W){1'b0}}};
								r_d     = REM_W'(BYTE_W);
								state_d = ST_EMIT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_ALIGN: begin
				// The code is left-aligned so that bits above its length fall off the top.
				sh_in   = {rd_code, {BYTE_W{1'b0}}};
				sh_req  = '{left: 1'b1, amt: SHAMT_W'(CODE_W) - SHAMT_W'(rd_len)};
				w_d     = (rd_len == '0) ? '0 : sh_out;
				r_d     = REM_W'(cnt_q) + REM_W'(rd_len);
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				sh_in   = w_q;
				sh_req  = '{left: 1'b0, amt: SHAMT_W'(cnt_q)};
				w_d     = {acc_q, {(WORK_W-ACC_W){1'b0}}} | sh_out;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (r_q >= REM_W'(BYTE_W)) begin
					if (!ov_q || result_ready) begin
						ov_d = 1'b1;
						ob_d = w_q[WORK_W-1 -: BYTE_W];
						lb_d = (r_q < REM_W'(2*BYTE_W));
						w_d  = sh_out;
						r_d  = r_q - REM_W'(BYTE_W);
					end
				end else begin
					acc_d   = w_q[WORK_W-1 -: ACC_W];
					cnt_d   = r_q[CNT_W-1:0];
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			r_q     <= '0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
			r_q     <= r_d;
		end
	end

	always_ff @(posedge clk) begin
		w_q  <= w_d;
		ob_q <= ob_d;
		lb_q <= lb_d;
	end

	assign result_valid = ov_q;
	assign out_byte     = ob_q;
	assign last_byte    = lb_q;

	`HTE_ASSERT_IMP(a_acc_tail_clear, state_q == ST_IDLE, BYTE_W'({acc_q, 1'b0} << cnt_q) == '0, "pending bits below the count are not clear")
	`HTE_ASSERT_NXT(a_flush_starts, item_valid && item_ready && op == OP_FLUSH && cnt_q != '0, state_q == ST_EMIT && r_q == REM_W'(BYTE_W), "flush did not start one byte")
	`HTE_ASSERT_IMP(a_bits_bounded, state_q == ST_MERGE || state_q == ST_EMIT, r_q <= REM_W'(CODE_W + ACC_W), "bit count beyond code and pending bits")
	`HTE_ASSERT_NXT(a_emit_closes, state_q == ST_EMIT && r_q < REM_W'(BYTE_W), state_q == ST_IDLE && cnt_q == $past(r_q[CNT_W-1:0]), "pending count not kept at close")

endmodule

// File: test/tb_huffman_table_encoder_bit_packer.sv
// Testbench for the table-driven prefix-code encoder and MSB-first byte packer.
// Depends on hte_pkg and huffman_table_encoder_bit_packer; predicts every byte and checks
// it against the output stream under random idling and long output stalls.
module tb_huffman_table_encoder_bit_packer;
	import hte_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} packed_byte_t;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	logic [1:0]        operation;
	logic [SYM_W-1:0]  symbol;
	logic [CODE_W-1:0] code_bits;
	logic [LEN_W-1:0]  code_length;
	logic              result_valid;
	logic              result_ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_byte;

	logic [CODE_W-1:0] code_mem_bits [SYMBOL_COUNT];
	logic [LEN_W-1:0]  code_mem_len [SYMBOL_COUNT];
	logic [ACC_W-1:0]  acc_bits;
	int unsigned       acc_count;
	packed_byte_t      expected_bytes[$];
	packed_byte_t      got;
	int                errors;
	int                stall_left;
	bit                steady;

	huffman_table_encoder_bit_packer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.symbol       (symbol),
		.code_bits    (code_bits),
		.code_length  (code_length),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.last_byte    (last_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb: failure");
		$finish;
	end

	// Works out the bytes that one accepted item releases and queues them; a load updates the model table.
	task automatic pack_item(input op_t op, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		logic [BYTE_W-1:0] widened;
		logic [BYTE_W-1:0] done_bytes[$];
		int unsigned       n;
		packed_byte_t      entry;
		case (op)
			OP_LOAD: begin
				code_mem_bits[sym] = code;
				code_mem_len[sym]  = (len > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : len;
			end
			OP_ENCODE: begin
				for (int i = int'(code_mem_len[sym]); i > 0; i--) begin
					widened = {acc_bits, code_mem_bits[sym][i-1]};
					if (acc_count == 7) begin
						done_bytes = {done_bytes, widened};
						acc_bits  = '0;
						acc_count = 0;
					end else begin
						acc_bits  = widened[ACC_W-1:0];
						acc_count = acc_count + 1;
					end
				end
				n = done_bytes.size();
				for (int k = 0; k < n; k++) begin
					entry.data     = done_bytes[k];
					entry.last     = (k == n - 1);
					expected_bytes = {expected_bytes, entry};
				end
			end
			OP_FLUSH: begin
				if (acc_count != 0) begin
					widened        = {1'b0, acc_bits} << (BYTE_W - acc_count);
					entry.data     = widened;
					entry.last     = 1'b1;
					expected_bytes = {expected_bytes, entry};
					acc_bits  = '0;
					acc_count = 0;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_item(input op_t op, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		while (!steady && $urandom_range(99) < 12) begin
			@(negedge clk);
			item_valid = 1'b0;
		end
		@(negedge clk);
		item_valid  = 1'b1;
		operation   = op;
		symbol      = sym;
		code_bits   = code;
		code_length = len;
		do
			@(posedge clk);
		while (!item_ready);
		pack_item(op, sym, code, len);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte %h last %b", $time, out_byte, last_byte);
				errors++;
			end else begin
				got = expected_bytes[0];
				expected_bytes.delete(0);
				if (out_byte !== got.data) begin
					$display("%0t: out_byte expected %h actual %h", $time, got.data, out_byte);
					errors++;
				end
				if (last_byte !== got.last) begin
					$display("%0t: last_byte expected %b actual %b", $time, got.last,
						last_byte);
					errors++;
				end
			end
		end
	end

	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ready = 1'b0;
				stall_left--;
			end else begin
				result_ready = steady || ($urandom_range(99) >= 12);
			end
		end
	end

	task automatic test_directed_codes();
		send_item(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
		send_item(OP_LOAD, 8'd255, 32'h0000_0000, 6'd1);
		send_item(OP_LOAD, 8'd1, 32'hFFFF_FFA5, 6'd8);
		send_item(OP_LOAD, 8'd2, 32'h1234_5678, 6'd63);
		send_item(OP_LOAD, 8'd3, 32'hDEAD_BEEF, 6'd0);
		send_item(OP_LOAD, 8'd4, 32'h0000_0005, 6'd3);
		send_item(OP_ENCODE, 8'd0, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd63);
		send_item(OP_ENCODE, 8'd1, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'd2, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'd4, 32'h0, 6'd0);
		send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
		wait_drained();
	endtask

	task automatic test_special_cases();
		send_item(OP_ENCODE, 8'd3, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'd200, 32'h0, 6'd0);
		send_item(OP_FLUSH, 8'd255, 32'hFFFF_FFFF, 6'd63);
		send_item(OP_NONE, 8'd255, 32'hFFFF_FFFF, 6'd63);
		send_item(OP_ENCODE, 8'd4, 32'h0, 6'd0);
		send_item(OP_NONE, 8'd0, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'd4, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'd255, 32'h0, 6'd0);
		send_item(OP_ENCODE, 8'd4, 32'h0, 6'd0);
		send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
		send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
		wait_drained();
	endtask

	task automatic test_output_stall();
		send_item(OP_LOAD, 8'd9, $urandom, 6'd32);
		stall_left = 300;
		for (int i = 0; i < 30; i++)
			send_item(OP_ENCODE, (i % 3 == 0) ? 8'd2 : 8'd9, $urandom, 6'd0);
		send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
		wait_drained();
	endtask

	task automatic random_item();
		int unsigned       r;
		logic [SYM_W-1:0]  sym;
		logic [LEN_W-1:0]  len;
		r   = $urandom_range(99);
		sym = ($urandom_range(99) < 80) ? SYM_W'($urandom_range(31)) : SYM_W'($urandom);
		if ($urandom_range(9) < 7)
			len = LEN_W'($urandom_range(12, 1));
		else if ($urandom_range(1) == 0)
			len = LEN_W'($urandom_range(32, 13));
		else
			len = LEN_W'($urandom_range(63));
		if (r < 15)
			send_item(OP_LOAD, sym, $urandom, len);
		else if (r < 85)
			send_item(OP_ENCODE, sym, $urandom, LEN_W'($urandom));
		else if (r < 95)
			send_item(OP_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
		else
			send_item(OP_NONE, SYM_W'($urandom), $urandom, LEN_W'($urandom));
	endtask

	task automatic test_random_traffic();
		for (int s = 0; s < 32; s++)
			send_item(OP_LOAD, SYM_W'(s), $urandom,
				LEN_W'(($urandom_range(4) == 0) ? $urandom_range(32, 13)
					: $urandom_range(12, 1)));
		for (int i = 0; i < 130; i++) begin
			steady = (i >= 40 && i < 110);
			random_item();
		end
		steady = 1'b0;
	endtask

	task automatic test_sender_pause();
		for (int i = 0; i < 20; i++)
			random_item();
		wait_drained();
		for (int i = 0; i < 80; i++)
			random_item();
		send_item(OP_FLUSH, 8'd0, 32'h0, 6'd0);
	endtask

	initial begin
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		operation   = OP_NONE;
		symbol      = '0;
		code_bits   = '0;
		code_length = '0;
		errors      = 0;
		stall_left  = 0;
		steady      = 1'b0;
		acc_bits    = '0;
		acc_count   = 0;
		for (int s = 0; s < SYMBOL_COUNT; s++) begin
			code_mem_bits[s] = '0;
			code_mem_len[s]  = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_codes();
		test_special_cases();
		test_output_stall();
		test_random_traffic();
		test_sender_pause();
		wait_drained();
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: huffman_table_encoder_bit_packer.f
+incdir+sv
sv/hte_pkg.sv
sv/hte_table.sv
sv/hte_shift.sv
sv/huffman_table_encoder_bit_packer.sv
test/tb_huffman_table_encoder_bit_packer.sv
